@@ rtl/aeg_pkg.sv @@
// ----------------------------------------------------------------------------
// aeg_pkg
// Shared types, codes and reset values for the ADSR envelope gain core.
// ----------------------------------------------------------------------------
package aeg_pkg;

    localparam int AEG_QUEUE_DEPTH = 2;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_ATTACK_STEP   = 3'd0;
    localparam logic [2:0] REG_DECAY_STEP    = 3'd1;
    localparam logic [2:0] REG_RELEASE_STEP  = 3'd2;
    localparam logic [2:0] REG_ATTACK_PEAK   = 3'd3;
    localparam logic [2:0] REG_SUSTAIN_LEVEL = 3'd4;

    localparam logic [15:0] RST_ATTACK_STEP   = 16'd5;
    localparam logic [15:0] RST_DECAY_STEP    = 16'd7;
    localparam logic [15:0] RST_RELEASE_STEP  = 16'd4;
    localparam logic [15:0] RST_ATTACK_PEAK   = 16'd32768;
    localparam logic [15:0] RST_SUSTAIN_LEVEL = 16'd27853;

    // Phase codes as reported on the result channel
    localparam logic [2:0] PHC_ATTACK  = 3'd0;
    localparam logic [2:0] PHC_DECAY   = 3'd1;
    localparam logic [2:0] PHC_SUSTAIN = 3'd2;
    localparam logic [2:0] PHC_RELEASE = 3'd3;
    localparam logic [2:0] PHC_DONE    = 3'd4;

    typedef enum logic [4:0] {
        PH_ATTACK  = 5'b00001,
        PH_DECAY   = 5'b00010,
        PH_SUSTAIN = 5'b00100,
        PH_RELEASE = 5'b01000,
        PH_DONE    = 5'b10000
    } phase_t;

    // One word between envelope front end and gain back end
    typedef struct packed {
        logic signed [15:0] sample;
        logic [15:0]        level;
        logic [2:0]         phase;
    } env_word_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        unique case (ph)
            PH_ATTACK:  code = PHC_ATTACK;
            PH_DECAY:   code = PHC_DECAY;
            PH_SUSTAIN: code = PHC_SUSTAIN;
            PH_RELEASE: code = PHC_RELEASE;
            PH_DONE:    code = PHC_DONE;
            default:    code = PHC_DONE;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/aeg_if.sv @@
// ----------------------------------------------------------------------------
// aeg_if
// Valid/ready stream interfaces for sample input and scaled result output.
// ----------------------------------------------------------------------------
interface aeg_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_in;
    logic               note_on;
    logic               note_off;

    modport source (output valid, output sample_in, output note_on, output note_off,
                    input ready);
    modport sink   (input valid, input sample_in, input note_on, input note_off,
                    output ready);
endinterface

interface aeg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;
    logic [2:0]         phase;

    modport source (output valid, output sample_out, output phase, input ready);
    modport sink   (input valid, input sample_out, input phase, output ready);
endinterface

@@ rtl/adsr_envelope_gain_core.sv @@
// ----------------------------------------------------------------------------
// adsr_envelope_gain_core
// Linear ADSR envelope applied as an unsigned Q1.15 gain to a 16-bit sample stream.
// ----------------------------------------------------------------------------
// Takes one sample word per clock while the FIFO has room and returns one
// scaled word per sample, in order. The envelope recurrence (note flags, one
// linear step, clamp and phase change) resolves combinationally in the front
// end; the 16x17 multiply and saturation sit in the back end ahead of the
// output register. Each word is registered in the FIFO and then in the output
// register before its result is valid. A QUEUE_DEPTH-entry FIFO between the
// two halves absorbs output stalls; input ready drops only when the FIFO is
// full. Configuration writes take effect on the next accepted sample.
// ----------------------------------------------------------------------------
module adsr_envelope_gain_core
    import aeg_pkg::*;
#(
    parameter int QUEUE_DEPTH = AEG_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    aeg_in_if.sink      item,
    aeg_out_if.source   result
);

    logic      q_full;
    logic      q_empty;
    logic      q_push;
    logic      q_pop;
    env_word_t q_wdata;
    env_word_t q_rdata;

    aeg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    aeg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    aeg_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

@@ rtl/aeg_front.sv @@
// ----------------------------------------------------------------------------
// aeg_front
// Register file and envelope state machine; one level update per word.
// ----------------------------------------------------------------------------
module aeg_front
    import aeg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    aeg_in_if.sink      item,
    input  logic        q_full,
    output logic        q_push,
    output env_word_t   q_wdata
);

    logic [15:0] attack_step_reg;
    logic [15:0] decay_step_reg;
    logic [15:0] release_step_reg;
    logic [15:0] attack_peak_reg;
    logic [15:0] sustain_level_reg;

    logic [15:0] level_reg, level_next;
    logic [15:0] target_reg, target_next;
    phase_t      phase_reg, phase_next;

    logic [15:0]        lvl0;
    logic [15:0]        tgt0;
    phase_t             ph0;
    logic signed [17:0] lv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_step_reg   <= RST_ATTACK_STEP;
            decay_step_reg    <= RST_DECAY_STEP;
            release_step_reg  <= RST_RELEASE_STEP;
            attack_peak_reg   <= RST_ATTACK_PEAK;
            sustain_level_reg <= RST_SUSTAIN_LEVEL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ATTACK_STEP:   attack_step_reg   <= cfg_data;
                REG_DECAY_STEP:    decay_step_reg    <= cfg_data;
                REG_RELEASE_STEP:  release_step_reg  <= cfg_data;
                REG_ATTACK_PEAK:   attack_peak_reg   <= cfg_data;
                REG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign item.ready = !q_full;
    assign q_push     = item.valid && !q_full;

    always_comb
    begin
        lvl0 = level_reg;
        tgt0 = target_reg;
        ph0  = phase_reg;
        // note-off is applied second so it wins
        if (item.note_on)
        begin
            lvl0 = '0;
            tgt0 = attack_peak_reg;
            ph0  = PH_ATTACK;
        end
        if (item.note_off)
        begin
            tgt0 = '0;
            ph0  = PH_RELEASE;
        end

        lv          = $signed({2'b00, lvl0});
        target_next = tgt0;
        phase_next  = ph0;
        unique case (ph0)
            PH_ATTACK:
            begin
                lv = lv + $signed({2'b00, attack_step_reg});
                if (lv >= $signed({2'b00, tgt0}))
                begin
                    lv          = $signed({2'b00, tgt0});
                    target_next = sustain_level_reg;
                    phase_next  = PH_DECAY;
                end
            end
            PH_DECAY:
            begin
                lv = lv - $signed({2'b00, decay_step_reg});
                if (lv <= $signed({2'b00, sustain_level_reg}))
                begin
                    lv         = $signed({2'b00, sustain_level_reg});
                    phase_next = PH_SUSTAIN;
                end
            end
            PH_RELEASE:
            begin
                lv = lv - $signed({2'b00, release_step_reg});
                if (lv <= 18'sd0)
                begin
                    lv         = '0;
                    phase_next = PH_DONE;
                end
            end
            PH_SUSTAIN, PH_DONE: ;
            default: ;
        endcase
        // clamps keep the level within 0..65535
        level_next = lv[15:0];

        q_wdata.sample = item.sample_in;
        q_wdata.level  = level_next;
        q_wdata.phase  = phase_code(phase_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= '0;
            target_reg <= '0;
            phase_reg  <= PH_DONE;
        end
        else if (q_push)
        begin
            level_reg  <= level_next;
            target_reg <= target_next;
            phase_reg  <= phase_next;
        end
    end

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && phase_reg == PH_DONE && !item.note_on && !item.note_off)
        |=> $stable(level_reg))
        else $error("level moved in done phase");

    a_release_target: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RELEASE) |-> (target_reg == 16'd0))
        else $error("release phase with nonzero ramp target");

endmodule

@@ rtl/aeg_queue.sv @@
// ----------------------------------------------------------------------------
// aeg_queue
// Short FIFO decoupling envelope front end from gain back end.
// ----------------------------------------------------------------------------
module aeg_queue
    import aeg_pkg::*;
#(
    parameter int DEPTH = AEG_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  env_word_t wdata,
    output logic      full,
    input  logic      pop,
    output env_word_t rdata,
    output logic      empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    env_word_t       mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full  = (count_reg == FULL_COUNT);
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("queue count beyond depth");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue count did not track a lone push");

endmodule

@@ rtl/aeg_back.sv @@
// ----------------------------------------------------------------------------
// aeg_back
// Gain stage: sample times level, floor shift by 15, saturate, output register.
// ----------------------------------------------------------------------------
module aeg_back
    import aeg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  env_word_t q_rdata,
    output logic      q_pop,
    aeg_out_if.source result
);

    logic               valid_reg;
    logic signed [15:0] sample_reg;
    logic [2:0]         phase_reg;

    logic signed [32:0] prod;
    logic signed [17:0] shifted;
    logic signed [15:0] sat;

    assign q_pop = !q_empty && (!valid_reg || result.ready);

    always_comb
    begin
        prod    = q_rdata.sample * $signed({1'b0, q_rdata.level});
        // dropping the low bits of a signed product floors toward minus infinity
        shifted = prod[32:15];
        if (shifted > 18'sd32767)
        begin
            sat = 16'sh7FFF;
        end
        else if (shifted < -18'sd32768)
        begin
            sat = -16'sh8000;
        end
        else
        begin
            sat = shifted[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sample_reg <= sat;
            phase_reg  <= q_rdata.phase;
        end
    end

    assign result.valid      = valid_reg;
    assign result.sample_out = sample_reg;
    assign result.phase      = phase_reg;

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> valid_reg)
        else $error("popped word not presented");

endmodule

@@ tb/adsr_envelope_gain_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_gain_core_tb
// Self-checking bench for the ADSR envelope gain core. A behavioral envelope
// tracks every accepted sample word and queues the scaled word it must produce;
// each output word is checked against the head of that queue. Directed cases
// cover the corners, then envelopes with random content run under many register
// settings, with random input gaps and output stalls in some of them.
// ----------------------------------------------------------------------------
module adsr_envelope_gain_core_tb;
    import aeg_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 100;

    typedef struct {
        logic signed [15:0] sample;
        logic [2:0]         phase;
    } scaled_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    aeg_in_if  in_if ();
    aeg_out_if out_if ();

    adsr_envelope_gain_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (in_if),
        .result    (out_if)
    );

    // register mirror
    int atk_step;
    int dec_step;
    int rel_step;
    int atk_peak;
    int sus_level;

    // envelope state mirror
    int         env_lvl;
    logic [2:0] env_ph;
    int         ramp_tgt;

    scaled_word_t scaled_q[$];
    scaled_word_t want;

    bit gaps_on;
    bit stalls_on;
    int stall_left;
    int idle_cycles;
    int errors;
    int words_sent;
    int words_checked;
    int reg_writes;
    int settings_used;
    int phase_seen[0:7];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 93)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic signed [15:0] rand_sample();
        if ($urandom_range(99) < 12)
        begin
            case ($urandom_range(4))
                0:       return 16'sh8000;
                1:       return 16'sh7FFF;
                2:       return 16'sh0000;
                3:       return 16'shFFFF;
                default: return 16'sh0001;
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_level();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 16'd0;
        if (r < 30)
            return 16'hFFFF;
        if (r < 45)
            return 16'd32768;
        return 16'($urandom_range(65535));
    endfunction

    // step sized so a ramp over span takes a modest number of samples
    function automatic logic [15:0] pick_step(input int span);
        int r;
        int d;
        r = $urandom_range(99);
        if (r < 6)
            return 16'd0;
        if (r < 12)
            return 16'hFFFF;
        if (r < 17)
            return 16'($urandom);
        d = span / $urandom_range(1, 48);
        if (d == 0)
            d = 1;
        return 16'(d);
    endfunction

    task automatic reset_model();
        atk_step  = RST_ATTACK_STEP;
        dec_step  = RST_DECAY_STEP;
        rel_step  = RST_RELEASE_STEP;
        atk_peak  = RST_ATTACK_PEAK;
        sus_level = RST_SUSTAIN_LEVEL;
        env_lvl   = 0;
        env_ph    = PHC_DONE;
        ramp_tgt  = 0;
    endtask

    // flags first, then one linear step, then the gain multiply
    function automatic scaled_word_t advance_envelope(input logic signed [15:0] s,
                                                      input logic on, input logic off);
        int           lv;
        longint       prod;
        scaled_word_t w;
        if (on)
        begin
            env_lvl  = 0;
            ramp_tgt = atk_peak;
            env_ph   = PHC_ATTACK;
        end
        if (off)
        begin
            ramp_tgt = 0;
            env_ph   = PHC_RELEASE;
        end
        lv = env_lvl;
        case (env_ph)
            PHC_ATTACK:
            begin
                lv = lv + atk_step;
                if (lv >= ramp_tgt)
                begin
                    lv       = ramp_tgt;
                    ramp_tgt = sus_level;
                    env_ph   = PHC_DECAY;
                end
            end
            PHC_DECAY:
            begin
                lv = lv - dec_step;
                if (lv <= sus_level)
                begin
                    lv     = sus_level;
                    env_ph = PHC_SUSTAIN;
                end
            end
            PHC_RELEASE:
            begin
                lv = lv - rel_step;
                if (lv <= 0)
                begin
                    lv     = 0;
                    env_ph = PHC_DONE;
                end
            end
            default: ;
        endcase
        env_lvl = lv;
        prod = (longint'(s) * longint'(env_lvl)) >>> 15;
        if (prod > 32767)
            prod = 32767;
        else if (prod < -32768)
            prod = -32768;
        w.sample = prod[15:0];
        w.phase  = env_ph;
        return w;
    endfunction

    task automatic send_word(input logic signed [15:0] s, input logic on, input logic off);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(99) < 30)
            gap = pick_len();
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.sample_in <= s;
        in_if.note_on   <= on;
        in_if.note_off  <= off;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        scaled_q.push_back(advance_envelope(s, on, off));
        words_sent++;
    endtask

    // stop sending and wait for every queued word to come out
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (scaled_q.size() != 0)
            @(posedge clk);
    endtask

    // leaves cfg_we high; cfg_release drops it
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        reg_writes++;
        case (idx)
            REG_ATTACK_STEP:   atk_step  = val;
            REG_DECAY_STEP:    dec_step  = val;
            REG_RELEASE_STEP:  rel_step  = val;
            REG_ATTACK_PEAK:   atk_peak  = val;
            REG_SUSTAIN_LEVEL: sus_level = val;
            default: ;
        endcase
    endtask

    task automatic cfg_release();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_settings(input logic [15:0] a, input logic [15:0] d,
                                  input logic [15:0] r, input logic [15:0] p,
                                  input logic [15:0] s);
        write_reg(REG_ATTACK_STEP, a);
        write_reg(REG_DECAY_STEP, d);
        write_reg(REG_RELEASE_STEP, r);
        write_reg(REG_ATTACK_PEAK, p);
        write_reg(REG_SUSTAIN_LEVEL, s);
        cfg_release();
        settings_used++;
    endtask

    // level zero and phase done straight out of reset; release from zero
    task automatic test_reset_state();
        send_word(16'sh7FFF, 1'b0, 1'b0);
        send_word(16'sh8000, 1'b0, 1'b0);
        send_word(16'sd1000, 1'b0, 1'b1);
    endtask

    // reset register values; -1 times a small level floors to -1;
    // note-off wins over note-on
    task automatic test_default_envelope();
        send_word(16'sh7FFF, 1'b1, 1'b0);
        send_word(16'shFFFF, 1'b0, 1'b0);
        send_word(16'sh8000, 1'b0, 1'b0);
        send_word(16'sd12345, 1'b1, 1'b1);
    endtask

    // gain above unity saturates both ways; decay lifts a level below sustain;
    // decay step that lands exactly on a zero sustain level
    task automatic test_unity_overshoot();
        drain_results();
        write_settings(16'd40000, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(16'sh7FFF, 1'b1, 1'b0);
        send_word(16'sh8000, 1'b0, 1'b0);
        send_word(16'sd100, 1'b0, 1'b0);
        send_word(16'sh8000, 1'b0, 1'b0);
        send_word(16'sd5, 1'b0, 1'b1);
        drain_results();
        write_reg(REG_SUSTAIN_LEVEL, 16'd0);
        write_reg(REG_DECAY_STEP, 16'hFFFF);
        cfg_release();
        send_word(-16'sd20000, 1'b1, 1'b0);
        send_word(16'sd20000, 1'b0, 1'b0);
        send_word(16'shFFFF, 1'b0, 1'b0);
    endtask

    // zero steps hold the level until the clamp compare passes
    task automatic test_zero_steps();
        drain_results();
        write_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_word(16'sh7FFF, 1'b1, 1'b0);
        send_word(16'sh8000, 1'b0, 1'b0);
        drain_results();
        write_settings(16'd0, 16'd0, 16'd0, 16'd100, 16'd50);
        send_word(16'sd1, 1'b1, 1'b0);
        drain_results();
        write_reg(REG_ATTACK_STEP, 16'd100);
        cfg_release();
        send_word(16'sd2, 1'b1, 1'b0);
        send_word(16'sd3, 1'b0, 1'b0);
        send_word(16'sd4, 1'b0, 1'b1);
        send_word(-16'sd5, 1'b0, 1'b0);
    endtask

    // writes past the last register must not land anywhere
    task automatic test_unused_index();
        drain_results();
        for (int i = int'(REG_SUSTAIN_LEVEL) + 1; i < 8; i++)
            write_reg(3'(i), 16'hFFFF);
        cfg_release();
        send_word(16'sh8000, 1'b1, 1'b0);
        send_word(16'sh7FFF, 1'b0, 1'b1);
    endtask

    task automatic test_random_envelopes(input int n_settings, input int per_setting);
        int          sent;
        int          hold;
        int          tail;
        int          n;
        logic [15:0] peak;
        logic [15:0] sus;
        for (int k = 0; k < n_settings; k++)
        begin
            drain_results();
            gaps_on   = (k % 4 == 0) || (k % 4 == 2);
            stalls_on = (k % 4 == 0) || (k % 4 == 3);
            case (k)
                0: write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: write_settings(16'd1, 16'd1, 16'd1, 16'd40, 16'd20);
                2: write_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                default:
                begin
                    peak = pick_level();
                    sus  = pick_level();
                    write_settings(pick_step(peak),
                                   pick_step(peak > sus ? peak - sus : sus),
                                   pick_step(peak > sus ? peak : sus), peak, sus);
                end
            endcase
            sent = 0;
            while (sent < per_setting)
            begin
                if ($urandom_range(99) < 85)
                begin
                    // note-on, hold, note-off, release tail
                    hold = ($urandom_range(99) < 90) ? $urandom_range(0, 60)
                                                     : $urandom_range(61, 200);
                    tail = $urandom_range(0, 40);
                    send_word(rand_sample(), 1'b1, 1'b0);
                    repeat (hold) send_word(rand_sample(), 1'b0, 1'b0);
                    send_word(rand_sample(), 1'b0, 1'b1);
                    repeat (tail) send_word(rand_sample(), 1'b0, 1'b0);
                    sent += hold + tail + 2;
                end
                else
                begin
                    n = $urandom_range(1, 10);
                    repeat (n)
                        send_word(rand_sample(), $urandom_range(7) == 0,
                                  $urandom_range(7) == 0);
                    sent += n;
                end
            end
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_ATTACK_STEP;
        cfg_data        <= 16'd0;
        in_if.valid     <= 1'b0;
        in_if.sample_in <= 16'sd0;
        in_if.note_on   <= 1'b0;
        in_if.note_off  <= 1'b0;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        reset_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_default_envelope();
        test_unity_overshoot();
        test_zero_steps();
        test_unused_index();
        // the last envelope of each setting runs past the count, so aim low
        test_random_envelopes(14, 85);

        drain_results();
        repeat (10) @(posedge clk);
        $display("Covered %0d sample words (%0d checked) under %0d register settings, %0d writes.",
                 words_sent, words_checked, settings_used, reg_writes);
        $display("Phases seen: attack %0d, decay %0d, sustain %0d, release %0d, done %0d.",
                 phase_seen[PHC_ATTACK], phase_seen[PHC_DECAY], phase_seen[PHC_SUSTAIN],
                 phase_seen[PHC_RELEASE], phase_seen[PHC_DONE]);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // output backpressure: bursts of ready with stalls, mostly short
    always @(posedge clk)
    begin
        if (!rst_n)
            out_if.ready <= 1'b0;
        else if (!stalls_on)
            out_if.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_if.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_if.ready <= 1'b1;
            if ($urandom_range(99) < 20)
                stall_left = pick_len();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (scaled_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected word, sample_out %0d phase %0d",
                             $time, out_if.sample_out, out_if.phase);
            end
            else
            begin
                want = scaled_q.pop_front();
                words_checked++;
                if (out_if.sample_out !== want.sample || out_if.phase !== want.phase)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: mismatch, sample_out exp %0d got %0d, phase exp %0d got %0d",
                                 $time, want.sample, out_if.sample_out, want.phase,
                                 out_if.phase);
                    if (errors == MAX_REPORTS)
                        $display("%0t: further mismatch reports suppressed", $time);
                end
                else
                    phase_seen[want.phase]++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, scaled_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

@@ sim.f @@
rtl/aeg_pkg.sv
rtl/aeg_if.sv
rtl/aeg_front.sv
rtl/aeg_queue.sv
rtl/aeg_back.sv
rtl/adsr_envelope_gain_core.sv
tb/adsr_envelope_gain_core_tb.sv
